>>> design/jtl_pkg.sv
`default_nettype none

package jtl_pkg;

	localparam int LENGTH_WIDTH_DEF = 16;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LBRACKET = 8'h5B;
	localparam logic [7:0] CH_RBRACKET = 8'h5D;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_LOWER_N = 8'h6E;
	localparam logic [7:0] CH_LOWER_R = 8'h72;

	localparam int KW_TRUE_IDX = 0;
	localparam int KW_FALSE_IDX = 1;
	localparam int KW_NULL_IDX = 2;
	localparam int KW_TRUE_LEN = 4;
	localparam int KW_FALSE_LEN = 5;
	localparam int KW_NULL_LEN = 4;

	typedef enum logic [3:0] {
		KIND_LBRACKET = 4'd0,
		KIND_RBRACKET = 4'd1,
		KIND_LBRACE = 4'd2,
		KIND_RBRACE = 4'd3,
		KIND_STRING = 4'd4,
		KIND_NUMBER = 4'd5,
		KIND_NULL = 4'd6,
		KIND_TRUE = 4'd7,
		KIND_FALSE = 4'd8,
		KIND_COLON = 4'd9,
		KIND_COMMA = 4'd10,
		KIND_ILLEGAL = 4'd11,
		KIND_UNCLOSED = 4'd12,
		KIND_STRBYTE = 4'd13
	} kind_t;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_WORD = 2'd1,
		MODE_STR = 2'd2,
		MODE_ESC = 2'd3
	} mode_t;

	typedef struct packed {
		kind_t kind;
		logic [7:0] char_value;
		logic [15:0] token_length;
		logic [63:0] number_value;
		logic last_in_run;
	} result_t;

	// Results produced by one byte, in order: r0 first, then r1.
	typedef struct packed {
		logic [1:0] n;
		result_t r0;
		result_t r1;
	} push_t;

	function automatic logic is_space(input logic [7:0] b);
		return (b == CH_SPACE) || (b == CH_LF) || (b == CH_CR) || (b == CH_TAB);
	endfunction

	function automatic logic is_punct(input logic [7:0] b);
		return (b == CH_LBRACKET) || (b == CH_RBRACKET) || (b == CH_LBRACE) ||
			(b == CH_RBRACE) || (b == CH_COLON) || (b == CH_COMMA);
	endfunction

	function automatic kind_t punct_kind(input logic [7:0] b);
		kind_t k;
		case (b)
			CH_LBRACKET: k = KIND_LBRACKET;
			CH_RBRACKET: k = KIND_RBRACKET;
			CH_LBRACE: k = KIND_LBRACE;
			CH_RBRACE: k = KIND_RBRACE;
			CH_COLON: k = KIND_COLON;
			CH_COMMA: k = KIND_COMMA;
			default: k = KIND_ILLEGAL;
		endcase
		return k;
	endfunction

	// Character of a keyword at a given position; zero past its end.
	function automatic logic [7:0] kw_char(input int idx, input logic [2:0] pos);
		logic [39:0] text;
		case (idx)
			KW_TRUE_IDX: text = {"true", 8'h00};
			KW_FALSE_IDX: text = "false";
			default: text = {"null", 8'h00};
		endcase
		case (pos)
			3'd0: return text[39:32];
			3'd1: return text[31:24];
			3'd2: return text[23:16];
			3'd3: return text[15:8];
			3'd4: return text[7:0];
			default: return 8'h00;
		endcase
	endfunction

endpackage

`default_nettype wire

>>> design/jtl_byte_if.sv
`default_nettype none

interface jtl_byte_if;
	logic valid;
	logic ready;
	logic [7:0] byte_value;
	logic end_of_input;

	modport source(output valid, output byte_value, output end_of_input, input ready);
	modport sink(input valid, input byte_value, input end_of_input, output ready);
endinterface

`default_nettype wire

>>> design/jtl_token_if.sv
`default_nettype none

interface jtl_token_if;
	logic valid;
	logic ready;
	logic [3:0] token_kind;
	logic [7:0] char_value;
	logic [15:0] token_length;
	logic [63:0] number_value;
	logic last_in_run;

	modport source(output valid, output token_kind, output char_value, output token_length,
		output number_value, output last_in_run, input ready);
	modport sink(input valid, input token_kind, input char_value, input token_length,
		input number_value, input last_in_run, output ready);
endinterface

`default_nettype wire

>>> design/jtl_core.sv
`default_nettype none

module jtl_core import jtl_pkg::*; #(
	parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	jtl_byte_if.sink byte_in,
	input wire logic room,
	output push_t push
);

	localparam int LW = LENGTH_WIDTH;
	localparam int WW = (LW > 16) ? LW : 16;
	localparam logic [LW-1:0] LEN_MAX = '1;

	logic valid_s1;
	logic [7:0] byte_s1;
	logic eoi_s1;

	mode_t mode_q;
	logic [LW-1:0] len_q;
	logic [63:0] acc_q;
	logic dig_q;
	logic [2:0] kw_q;

	mode_t a_mode, d_mode;
	logic [LW-1:0] a_len, d_len;
	logic [63:0] a_acc, d_acc;
	logic a_dig, d_dig;
	logic [2:0] a_kw, d_kw;

	logic fire;
	logic b_space, b_punct, b_quote, b_bslash, b_term, b_digit;
	logic [LW-1:0] len_inc;
	logic [63:0] wb_acc;
	logic wb_dig;
	logic [2:0] wb_kw;
	logic [7:0] esc_char;
	result_t punct_res, cw_cur, cw_after;
	result_t res0, res1;
	logic [1:0] res_n;

	function automatic logic [15:0] sat16(input logic [LW-1:0] len);
		logic [WW-1:0] w;
		w = WW'(len);
		return (w > WW'(16'hFFFF)) ? 16'hFFFF : w[15:0];
	endfunction

	function automatic result_t mk(input kind_t k, input logic [7:0] ch,
		input logic [15:0] len, input logic [63:0] num);
		result_t r;
		r.kind = k;
		r.char_value = ch;
		r.token_length = len;
		r.number_value = num;
		r.last_in_run = 1'b0;
		return r;
	endfunction

	function automatic logic kw_ok(input int idx, input int kw_len, input logic [LW-1:0] len,
		input logic [7:0] b);
		logic short;
		short = len < LW'(kw_len);
		return short && (kw_char(idx, len[2:0]) == b);
	endfunction

	function automatic result_t close_word(input logic [LW-1:0] len, input logic dig,
		input logic [2:0] kw, input logic [63:0] acc);
		kind_t k;
		k = dig ? KIND_NUMBER : KIND_ILLEGAL;
		if (kw[KW_TRUE_IDX] && (len == LW'(KW_TRUE_LEN))) k = KIND_TRUE;
		if (kw[KW_FALSE_IDX] && (len == LW'(KW_FALSE_LEN))) k = KIND_FALSE;
		if (kw[KW_NULL_IDX] && (len == LW'(KW_NULL_LEN))) k = KIND_NULL;
		return mk(k, 8'h00, sat16(len), (k == KIND_NUMBER) ? acc : 64'h0);
	endfunction

	assign fire = valid_s1 && room;
	assign byte_in.ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_in.ready) begin
			valid_s1 <= byte_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_in.valid && byte_in.ready) begin
			byte_s1 <= byte_in.byte_value;
			eoi_s1 <= byte_in.end_of_input;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			len_q <= '0;
			acc_q <= 64'h0;
			dig_q <= 1'b1;
			kw_q <= 3'b111;
		end else if (fire) begin
			mode_q <= d_mode;
			len_q <= d_len;
			acc_q <= d_acc;
			dig_q <= d_dig;
			kw_q <= d_kw;
		end
	end

	assign b_space = is_space(byte_s1);
	assign b_punct = is_punct(byte_s1);
	assign b_quote = byte_s1 == CH_QUOTE;
	assign b_bslash = byte_s1 == CH_BSLASH;
	assign b_term = b_space || b_punct || b_quote;
	assign b_digit = (byte_s1 >= CH_ZERO) && (byte_s1 <= CH_NINE);
	assign len_inc = (len_q == LEN_MAX) ? len_q : len_q + LW'(1);

	// Times ten is a pair of shifts; no multiplier is needed.
	assign wb_acc = b_digit ? (acc_q << 3) + (acc_q << 1) + 64'(byte_s1[3:0]) : acc_q;
	assign wb_dig = dig_q && b_digit;
	assign wb_kw[KW_TRUE_IDX] = kw_q[KW_TRUE_IDX] && kw_ok(KW_TRUE_IDX, KW_TRUE_LEN, len_q, byte_s1);
	assign wb_kw[KW_FALSE_IDX] = kw_q[KW_FALSE_IDX] &&
		kw_ok(KW_FALSE_IDX, KW_FALSE_LEN, len_q, byte_s1);
	assign wb_kw[KW_NULL_IDX] = kw_q[KW_NULL_IDX] && kw_ok(KW_NULL_IDX, KW_NULL_LEN, len_q, byte_s1);

	assign esc_char = (byte_s1 == CH_LOWER_N) ? CH_LF :
		((byte_s1 == CH_LOWER_R) ? CH_CR : byte_s1);

	assign punct_res = mk(punct_kind(byte_s1), byte_s1, 16'd1, 64'h0);
	assign cw_cur = close_word(len_q, dig_q, kw_q, acc_q);
	assign cw_after = close_word(a_len, a_dig, a_kw, a_acc);

	// Next state. The idle mode always holds cleared run state, so a word
	// that starts from idle builds on the current registers directly.
	always_comb begin
		a_mode = mode_q;
		a_len = len_q;
		a_acc = acc_q;
		a_dig = dig_q;
		a_kw = kw_q;
		case (mode_q)
			MODE_IDLE: begin
				if (b_quote) begin
					a_mode = MODE_STR;
				end else if (!b_space && !b_punct) begin
					a_mode = MODE_WORD;
					a_len = len_inc;
					a_acc = wb_acc;
					a_dig = wb_dig;
					a_kw = wb_kw;
				end
			end
			MODE_WORD: begin
				if (b_term) begin
					a_mode = b_quote ? MODE_STR : MODE_IDLE;
					a_len = '0;
					a_acc = 64'h0;
					a_dig = 1'b1;
					a_kw = 3'b111;
				end else begin
					a_len = len_inc;
					a_acc = wb_acc;
					a_dig = wb_dig;
					a_kw = wb_kw;
				end
			end
			MODE_STR: begin
				if (b_quote) begin
					a_mode = MODE_IDLE;
					a_len = '0;
				end else if (b_bslash) begin
					a_mode = MODE_ESC;
				end else begin
					a_len = len_inc;
				end
			end
			default: begin
				a_mode = MODE_STR;
				a_len = len_inc;
			end
		endcase

		d_mode = a_mode;
		d_len = a_len;
		d_acc = a_acc;
		d_dig = a_dig;
		d_kw = a_kw;
		if (eoi_s1) begin
			d_mode = MODE_IDLE;
			d_len = '0;
			d_acc = 64'h0;
			d_dig = 1'b1;
			d_kw = 3'b111;
		end
	end

	// Results of the byte, at most two, in the order they are due.
	always_comb begin
		res_n = 2'd0;
		res0 = mk(KIND_ILLEGAL, 8'h00, 16'd0, 64'h0);
		res1 = res0;
		case (mode_q)
			MODE_IDLE: begin
				if (b_punct) begin
					res0 = punct_res;
					res_n = 2'd1;
				end
			end
			MODE_WORD: begin
				if (b_term) begin
					res0 = cw_cur;
					res_n = 2'd1;
					if (b_punct) begin
						res1 = punct_res;
						res_n = 2'd2;
					end
				end
			end
			MODE_STR: begin
				if (b_quote) begin
					res0 = mk(KIND_STRING, 8'h00, sat16(len_q), 64'h0);
					res_n = 2'd1;
				end else if (!b_bslash) begin
					res0 = mk(KIND_STRBYTE, byte_s1, 16'd0, 64'h0);
					res_n = 2'd1;
				end
			end
			default: begin
				res0 = mk(KIND_STRBYTE, esc_char, 16'd0, 64'h0);
				res_n = 2'd1;
			end
		endcase

		if (eoi_s1 && (a_mode != MODE_IDLE)) begin
			if (res_n == 2'd0) begin
				res0 = (a_mode == MODE_WORD) ? cw_after :
					mk(KIND_UNCLOSED, 8'h00, sat16(a_len), 64'h0);
			end else begin
				res1 = (a_mode == MODE_WORD) ? cw_after :
					mk(KIND_UNCLOSED, 8'h00, sat16(a_len), 64'h0);
			end
			res_n = res_n + 2'd1;
		end

		if (res_n == 2'd1) res0.last_in_run = 1'b1;
		if (res_n == 2'd2) res1.last_in_run = 1'b1;
	end

	assign push.n = fire ? res_n : 2'd0;
	assign push.r0 = res0;
	assign push.r1 = res1;

`ifndef SYNTHESIS
	a_eoi_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && eoi_s1 |=> mode_q == MODE_IDLE && len_q == '0)
		else $error("run state not cleared after the final byte");
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_IDLE |-> len_q == '0 && acc_q == 64'h0 && dig_q && kw_q == 3'b111)
		else $error("idle mode holds stale run state");
	a_push_bound: assert property (@(posedge clk) disable iff (!arst_n)
		push.n != 2'd3 && (push.n == 2'd0 || room))
		else $error("results pushed beyond the queue space");
`endif

endmodule

`default_nettype wire

>>> design/jtl_res_fifo.sv
`default_nettype none

module jtl_res_fifo import jtl_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire push_t push,
	output logic room,
	jtl_token_if.source token_out
);

	result_t mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;
	logic rd;
	result_t head;

	// Two free entries are needed, as one byte may give two results.
	assign room = count_q <= FIFO_CNT_W'(FIFO_DEPTH - 2);
	assign rd = token_out.valid && token_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(push.n);
			rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(rd);
			count_q <= count_q + FIFO_CNT_W'(push.n) - FIFO_CNT_W'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) mem_q[wr_ptr_q] <= push.r0;
		if (push.n == 2'd2) mem_q[wr_ptr_q + FIFO_PTR_W'(1)] <= push.r1;
	end

	assign head = mem_q[rd_ptr_q];
	assign token_out.valid = count_q != '0;
	assign token_out.token_kind = head.kind;
	assign token_out.char_value = head.char_value;
	assign token_out.token_length = head.token_length;
	assign token_out.number_value = head.number_value;
	assign token_out.last_in_run = head.last_in_run;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FIFO_CNT_W'(FIFO_DEPTH))
		else $error("result queue count beyond its depth");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.n != 2'd0 |-> count_q <= FIFO_CNT_W'(FIFO_DEPTH - 2))
		else $error("result queue written without space");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		FIFO_PTR_W'(count_q) == FIFO_PTR_W'(wr_ptr_q - rd_ptr_q))
		else $error("result queue pointers disagree with count");
`endif

endmodule

`default_nettype wire

>>> design/json_token_lexer.sv
`default_nettype none

// Streaming JSON lexer: takes one byte of text per item and gives token items
// on the output channel, in order. Each accepted byte is held in an input
// register until its results are formed there and written into a four-entry
// result queue, from which the output is read. A byte is accepted every cycle
// while the queue has two free entries; the sustained rate is one byte per
// cycle as long as bytes give at most one result each and the output is not
// held back, and the queue drain of one result per cycle, while the output is
// ready, sets the pace when bytes give two (a word closed by punctuation, or a
// byte that gives a result and ends the text while a run is still open). A byte
// that gives no result (whitespace, an opening quote, a backslash, a word byte)
// still passes through the input register like any other. LENGTH_WIDTH sets the
// width of the internal run-length counter; the reported length saturates at 65535.
module json_token_lexer import jtl_pkg::*; #(
	parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	jtl_byte_if.sink byte_in,
	jtl_token_if.source token_out
);

	push_t push;
	logic room;

	jtl_core #(
		.LENGTH_WIDTH(LENGTH_WIDTH)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.byte_in(byte_in),
		.room(room),
		.push(push)
	);

	jtl_res_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.room(room),
		.token_out(token_out)
	);

endmodule

`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import jtl_pkg::*;

	localparam int LEN_W = LENGTH_WIDTH_DEF;

	// Tracks the lexer's state byte by byte and holds the tokens that are still due.
	class token_checker;
		static string kw_word[3] = '{"true", "false", "null"};
		static kind_t kw_kind[3] = '{KIND_TRUE, KIND_FALSE, KIND_NULL};

		result_t tokens_due[$];
		int fail_count;
		int seen;
		mode_t mode;
		logic [LEN_W-1:0] run_len;
		logic [63:0] digits;
		bit all_digits;
		logic [2:0] kw_live;

		function new();
			fail_count = 0;
			seen = 0;
			restart();
		endfunction

		static function bit blank(logic [7:0] b);
			return b == CH_SPACE || b == CH_LF || b == CH_CR || b == CH_TAB;
		endfunction

		static function bit punct_of(logic [7:0] b, output kind_t k);
			k = KIND_ILLEGAL;
			case (b)
				CH_LBRACKET: k = KIND_LBRACKET;
				CH_RBRACKET: k = KIND_RBRACKET;
				CH_LBRACE: k = KIND_LBRACE;
				CH_RBRACE: k = KIND_RBRACE;
				CH_COLON: k = KIND_COLON;
				CH_COMMA: k = KIND_COMMA;
				default: return 1'b0;
			endcase
			return 1'b1;
		endfunction

		static function bit ends_word(logic [7:0] b);
			kind_t k;
			return blank(b) || punct_of(b, k) || b == CH_QUOTE;
		endfunction

		function void restart();
			mode = MODE_IDLE;
			run_len = '0;
			digits = '0;
			all_digits = 1'b1;
			kw_live = 3'b111;
		endfunction

		function void bump();
			if (run_len != {LEN_W{1'b1}})
				run_len++;
		endfunction

		function void add_result(kind_t k, logic [7:0] ch, longint unsigned len,
				logic [63:0] num);
			result_t r;
			r.kind = k;
			r.char_value = ch;
			r.token_length = (len > 65535) ? 16'hFFFF : 16'(len);
			r.number_value = num;
			r.last_in_run = 1'b0;
			tokens_due.push_back(r);
		endfunction

		function void word_byte(logic [7:0] b);
			for (int i = 0; i < 3; i++)
				if (!(run_len < kw_word[i].len() && kw_word[i][run_len] == b))
					kw_live[i] = 1'b0;
			if (b >= CH_ZERO && b <= CH_NINE)
				digits = digits * 64'd10 + 64'(b - CH_ZERO);
			else
				all_digits = 1'b0;
			bump();
		endfunction

		function void close_word();
			kind_t k;
			k = all_digits ? KIND_NUMBER : KIND_ILLEGAL;
			for (int i = 0; i < 3; i++)
				if (kw_live[i] && run_len == kw_word[i].len())
					k = kw_kind[i];
			add_result(k, 8'h00, run_len, (k == KIND_NUMBER) ? digits : 64'd0);
			restart();
		endfunction

		function void take_idle(logic [7:0] b);
			kind_t k;
			if (blank(b))
				return;
			if (punct_of(b, k)) begin
				add_result(k, b, 1, 64'd0);
			end else if (b == CH_QUOTE) begin
				restart();
				mode = MODE_STR;
			end else begin
				restart();
				mode = MODE_WORD;
				word_byte(b);
			end
		endfunction

		function void lex_byte(logic [7:0] b, bit eoi);
			int first;
			result_t tail;
			first = tokens_due.size();
			case (mode)
				MODE_IDLE: take_idle(b);
				MODE_WORD: begin
					if (ends_word(b)) begin
						close_word();
						take_idle(b);
					end else begin
						word_byte(b);
					end
				end
				MODE_STR: begin
					if (b == CH_QUOTE) begin
						add_result(KIND_STRING, 8'h00, run_len, 64'd0);
						restart();
					end else if (b == CH_BSLASH) begin
						mode = MODE_ESC;
					end else begin
						add_result(KIND_STRBYTE, b, 0, 64'd0);
						bump();
					end
				end
				default: begin
					// Only n and r are translated; every other escaped byte passes as it is.
					add_result(KIND_STRBYTE, (b == CH_LOWER_N) ? CH_LF :
						(b == CH_LOWER_R) ? CH_CR : b, 0, 64'd0);
					bump();
					mode = MODE_STR;
				end
			endcase
			if (eoi) begin
				if (mode == MODE_WORD)
					close_word();
				else if (mode == MODE_STR || mode == MODE_ESC)
					add_result(KIND_UNCLOSED, 8'h00, run_len, 64'd0);
				restart();
			end
			if (tokens_due.size() > first) begin
				tail = tokens_due.pop_back();
				tail.last_in_run = 1'b1;
				tokens_due.push_back(tail);
			end
		endfunction

		task report(string what);
			fail_count++;
			if (fail_count <= 40)
				$display("[%0t] token %0d: %s", $time, seen, what);
		endtask

		task check_token(result_t got);
			result_t want;
			if (tokens_due.size() == 0) begin
				report($sformatf("unexpected item, kind %0d", got.kind));
			end else begin
				want = tokens_due.pop_front();
				if (got.kind !== want.kind)
					report($sformatf("kind %0d, want %0d", got.kind, want.kind));
				if (got.char_value !== want.char_value)
					report($sformatf("char_value %0h, want %0h", got.char_value,
						want.char_value));
				if (got.token_length !== want.token_length)
					report($sformatf("token_length %0d, want %0d", got.token_length,
						want.token_length));
				if (got.number_value !== want.number_value)
					report($sformatf("number_value %0d, want %0d", got.number_value,
						want.number_value));
				if (got.last_in_run !== want.last_in_run)
					report($sformatf("last_in_run %0b, want %0b", got.last_in_run,
						want.last_in_run));
			end
			seen++;
		endtask
	endclass

	logic clk;
	logic arst_n;

	jtl_byte_if byte_if();
	jtl_token_if token_if();

	json_token_lexer u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_in(byte_if),
		.token_out(token_if)
	);

	token_checker sb = new();

	logic [7:0] punct_set[6] = '{CH_LBRACKET, CH_RBRACKET, CH_LBRACE, CH_RBRACE, CH_COLON,
		CH_COMMA};
	logic [7:0] blank_set[4] = '{CH_SPACE, CH_LF, CH_CR, CH_TAB};
	logic [7:0] text_q[$];
	bit tx_calm = 1'b0;
	bit rx_calm = 1'b0;
	int fed = 0;

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// Mostly short pauses with the odd long one; calm spells give runs with none.
	function automatic int pause_len(inout bit calm);
		int r;
		if ($urandom_range(0, 49) == 0)
			calm = !calm;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 24);
	endfunction

	task automatic send_byte(input logic [7:0] b, input bit eoi);
		int gap;
		gap = pause_len(tx_calm);
		if (gap > 0) begin
			byte_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_if.valid <= 1'b1;
		byte_if.byte_value <= b;
		byte_if.end_of_input <= eoi;
		do @(posedge clk); while (byte_if.ready !== 1'b1);
		sb.lex_byte(b, eoi);
		fed++;
	endtask

	task automatic send_str(input string s, input bit eoi);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], eoi && i == s.len() - 1);
	endtask

	function automatic logic [7:0] plain_byte();
		logic [7:0] c;
		do c = 8'($urandom_range(0, 255)); while (c == CH_QUOTE || c == CH_BSLASH);
		return c;
	endfunction

	// Appends one lexical piece of random content to the text being built.
	function automatic void add_piece();
		int n;
		int sel;
		logic [7:0] c;
		string w;
		sel = $urandom_range(0, 9);
		case (sel)
			0, 1: text_q.push_back(punct_set[$urandom_range(0, 5)]);
			2, 9: begin
				w = token_checker::kw_word[$urandom_range(0, 2)];
				if (sel == 2) begin
					case ($urandom_range(0, 3))
						1: w = w.substr(0, w.len() - 2);
						2: w = {w, "s"};
						3: w[0] = w[0] - 8'd32;
						default: ;
					endcase
				end
				for (int i = 0; i < w.len(); i++)
					text_q.push_back(w[i]);
			end
			3, 4: begin
				n = ($urandom_range(0, 7) == 0) ? $urandom_range(19, 26) : $urandom_range(1, 6);
				for (int i = 0; i < n; i++)
					text_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
			end
			5, 6: begin
				text_q.push_back(CH_QUOTE);
				n = $urandom_range(0, 10);
				for (int i = 0; i < n; i++) begin
					if ($urandom_range(0, 4) == 0) begin
						text_q.push_back(CH_BSLASH);
						case ($urandom_range(0, 4))
							0: text_q.push_back(CH_LOWER_N);
							1: text_q.push_back(CH_LOWER_R);
							2: text_q.push_back(CH_QUOTE);
							3: text_q.push_back(CH_BSLASH);
							default: text_q.push_back(8'($urandom_range(0, 255)));
						endcase
					end else begin
						text_q.push_back(plain_byte());
					end
				end
				if ($urandom_range(0, 9) != 0)
					text_q.push_back(CH_QUOTE);
			end
			7: begin
				n = $urandom_range(1, 5);
				for (int i = 0; i < n; i++) begin
					do c = 8'($urandom_range(0, 255)); while (token_checker::ends_word(c));
					text_q.push_back(c);
				end
			end
			default: begin
				n = $urandom_range(1, 3);
				for (int i = 0; i < n; i++)
					text_q.push_back(blank_set[$urandom_range(0, 3)]);
			end
		endcase
	endfunction

	initial begin
		#20_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		int gap;
		int taken;
		result_t got;
		taken = 0;
		wait (arst_n === 1'b1);
		forever begin
			// Two long hold-offs let the result queue fill and push back on the input.
			gap = (taken == 200 || taken == 700) ? 400 : pause_len(rx_calm);
			if (gap > 0) begin
				token_if.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			token_if.ready <= 1'b1;
			do @(posedge clk); while (token_if.valid !== 1'b1);
			got.kind = kind_t'(token_if.token_kind);
			got.char_value = token_if.char_value;
			got.token_length = token_if.token_length;
			got.number_value = token_if.number_value;
			got.last_in_run = token_if.last_in_run;
			sb.check_token(got);
			taken++;
		end
	end

	initial begin
		int n;
		bit eoi_end;
		arst_n = 1'b0;
		byte_if.valid = 1'b0;
		byte_if.byte_value = 8'h00;
		byte_if.end_of_input = 1'b0;
		token_if.ready = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Punctuation, three known escapes and one unknown escape, a keyword and a number.
		send_str("[{\"\\n\\\"\\\\\\q\":null,9}]", 1'b0);
		send_byte(CH_TAB, 1'b0);
		send_byte(CH_LF, 1'b0);
		send_byte(CH_CR, 1'b0);
		send_byte(CH_SPACE, 1'b0);
		send_byte(8'hFF, 1'b1);
		// A word closed by a quote, then a string cut short by the end of the text.
		send_byte(8'h00, 1'b0);
		send_byte(CH_QUOTE, 1'b0);
		send_str("\\r", 1'b1);
		send_byte(CH_QUOTE, 1'b0);
		send_byte(CH_BSLASH, 1'b1);

		fed = 0;
		while (fed < 1550) begin
			text_q.delete();
			if ($urandom_range(0, 9) < 8) begin
				n = $urandom_range(1, 12);
				for (int i = 0; i < n; i++) begin
					add_piece();
					if ($urandom_range(0, 1) == 0)
						text_q.push_back(blank_set[$urandom_range(0, 3)]);
				end
				eoi_end = ($urandom_range(0, 2) == 0);
				for (int i = 0; i < text_q.size(); i++)
					send_byte(text_q[i], eoi_end && i == text_q.size() - 1);
			end else begin
				n = $urandom_range(1, 8);
				for (int i = 0; i < n; i++)
					send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
			end
		end

		byte_if.valid <= 1'b0;
		while (sb.tokens_due.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

>>> files.f
design/jtl_pkg.sv
design/jtl_byte_if.sv
design/jtl_token_if.sv
design/jtl_core.sv
design/jtl_res_fifo.sv
design/json_token_lexer.sv
tb/testbench.sv
